// File: design/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
// Used by the front classifier, the request queue, the back sequencer and the checker.
`default_nettype none

package mbsp_pkg;

    localparam logic [7:0] RT_MIN         = 8'hF8;
    localparam logic [7:0] SYSEX_END_BYTE = 8'hF7;
    localparam logic [8:0] LIMIT_RESET    = 9'h100;
    localparam int unsigned LIMIT_MAX     = 511;

    // Class of one received byte, decided in the front part.
    typedef enum logic [2:0] {
        CL_DATA  = 3'd0,
        CL_RT    = 3'd1,
        CL_ONE   = 3'd2,
        CL_TWO   = 3'd3,
        CL_SYSEX = 3'd4,
        CL_END   = 3'd5,
        CL_UNDEF = 3'd6
    } byte_class_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_RT     = 3'd1,
        EV_ONE    = 3'd2,
        EV_TWO    = 3'd3,
        EV_SXDATA = 3'd4,
        EV_SXEND  = 3'd5
    } event_kind_t;

    typedef enum logic [1:0] {
        RC_OK    = 2'd0,
        RC_UNDEF = 2'd1,
        RC_FULL  = 2'd2
    } result_code_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FIRST  = 5'b00010,
        ST_SECOND = 5'b00100,
        ST_SYSEX  = 5'b01000,
        ST_ONE    = 5'b10000
    } parse_state_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  rx_byte;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } handshake_t;

    typedef struct packed {
        event_kind_t  event_kind;
        logic [7:0]   status_value;
        logic [6:0]   first_data;
        logic [6:0]   second_data;
        logic [8:0]   sysex_count;
        result_code_t result_code;
    } result_t;

endpackage

`default_nettype wire

// File: design/mbsp_byte_if.sv
// Input channel carrying one received MIDI byte per request.
// Stands alone; no package dependency.
`default_nettype none

interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/mbsp_event_if.sv
// Output channel carrying one parser result per request.
// Stands alone; no package dependency.
`default_nettype none

interface mbsp_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] status_value;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [8:0] sysex_count;
    logic [1:0] result_code;

    modport source (output valid, output event_kind, output status_value,
                    output first_data, output second_data, output sysex_count,
                    output result_code, input ready);
    modport sink (input valid, input event_kind, input status_value,
                  input first_data, input second_data, input sysex_count,
                  input result_code, output ready);
endinterface

`default_nettype wire

// File: design/midi_byte_stream_parser.sv
// MIDI byte stream parser: one result per received byte, running status kept.
// Each accepted byte is registered in the request queue, then in the result stage.
// Throughput: one byte per cycle while ev.ready stays high, set by the parse state machine.
// A two-entry queue absorbs back-pressure; rx.ready drops only when it is full.
// Reset (rst_n low, asynchronous) idles the parser, clears running status and
// the sysex index, sets the sysex limit to 256 and empties queue and result stage.
`default_nettype none

module midi_byte_stream_parser #(
    parameter int unsigned SYSEX_MAX = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mbsp_byte_if.sink       rx,
    mbsp_event_if.source    ev,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata
);

    mbsp_pkg::entry_t push_entry;
    mbsp_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             not_empty;

    mbsp_front u_front (
        .rx         (rx),
        .q_full     (q_full),
        .push_entry (push_entry),
        .push       (push)
    );

    mbsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty)
    );

    mbsp_back #(
        .SYSEX_MAX (SYSEX_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .ev        (ev)
    );

endmodule

`default_nettype wire

// File: design/mbsp_front.sv
// Front part: accepts received bytes and classifies them for the back sequencer.
// Depends on mbsp_pkg and mbsp_byte_if.
`default_nettype none

module mbsp_front (
    mbsp_byte_if.sink         rx,
    input  wire logic         q_full,
    output mbsp_pkg::entry_t  push_entry,
    output logic              push
);

    mbsp_pkg::byte_class_t cls;

    always_comb
    begin
        if (!rx.rx_byte[7])
        begin
            cls = mbsp_pkg::CL_DATA;
        end
        else if (rx.rx_byte >= mbsp_pkg::RT_MIN)
        begin
            cls = mbsp_pkg::CL_RT;
        end
        else
        begin
            unique case (rx.rx_byte[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: cls = mbsp_pkg::CL_TWO;
                4'hC, 4'hD:                   cls = mbsp_pkg::CL_ONE;
                default:
                begin
                    // System common range: only a few codes are defined.
                    unique case (rx.rx_byte[3:0]) inside
                        4'h0:       cls = mbsp_pkg::CL_SYSEX;
                        4'h1, 4'h3: cls = mbsp_pkg::CL_ONE;
                        4'h2:       cls = mbsp_pkg::CL_TWO;
                        4'h7:       cls = mbsp_pkg::CL_END;
                        default:    cls = mbsp_pkg::CL_UNDEF;
                    endcase
                end
            endcase
        end
    end

    assign rx.ready           = !q_full;
    assign push               = rx.valid && !q_full;
    assign push_entry.cls     = cls;
    assign push_entry.rx_byte = rx.rx_byte;

endmodule

`default_nettype wire

// File: design/mbsp_queue.sv
// Two-entry request queue between the front classifier and the back sequencer.
// Depends on mbsp_pkg.
`default_nettype none

module mbsp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mbsp_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output mbsp_pkg::entry_t       head,
    output logic                   not_empty
);

    mbsp_pkg::entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbsp_back.sv
// Back part: parse state machine with running status and sysex counting,
// feeding a registered result stage. Depends on mbsp_pkg and mbsp_event_if.
`default_nettype none

module mbsp_back #(
    parameter int unsigned SYSEX_MAX = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [8:0]        cfg_wdata,
    input  wire mbsp_pkg::entry_t  head,
    input  wire logic              not_empty,
    output logic                   pop,
    mbsp_event_if.source           ev
);

    localparam int unsigned CapLim = (SYSEX_MAX > mbsp_pkg::LIMIT_MAX) ?
                                     mbsp_pkg::LIMIT_MAX : SYSEX_MAX;
    localparam logic [8:0] CAP = 9'(CapLim);

    mbsp_pkg::parse_state_t state_reg, state_next;
    logic [7:0]        running_reg, running_next;
    logic [6:0]        held_reg, held_next;
    logic [8:0]        index_reg, index_next;
    logic [8:0]        limit_reg;
    logic [8:0]        eff_limit;
    logic              out_valid_reg;
    mbsp_pkg::result_t out_reg, res;
    mbsp_pkg::handshake_t out_hs;

    assign eff_limit    = (limit_reg > CAP) ? CAP : limit_reg;
    assign out_hs.valid = out_valid_reg;
    assign out_hs.ready = ev.ready;
    // The result stage takes a new request whenever it is empty or being drained.
    assign pop          = not_empty && (!out_hs.valid || out_hs.ready);

    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        held_next    = held_reg;
        index_next   = index_reg;
        res          = '{mbsp_pkg::EV_NONE, 8'h00, 7'h00, 7'h00, 9'h000, mbsp_pkg::RC_OK};
        unique case (head.cls)
            mbsp_pkg::CL_RT:
            begin
                res.event_kind   = mbsp_pkg::EV_RT;
                res.status_value = head.rx_byte;
            end
            mbsp_pkg::CL_END:
            begin
                if (state_reg == mbsp_pkg::ST_SYSEX)
                begin
                    res.event_kind   = mbsp_pkg::EV_SXEND;
                    res.status_value = mbsp_pkg::SYSEX_END_BYTE;
                    res.sysex_count  = index_reg;
                end
                else
                begin
                    res.result_code = mbsp_pkg::RC_UNDEF;
                end
                state_next = mbsp_pkg::ST_IDLE;
            end
            mbsp_pkg::CL_ONE:
            begin
                state_next   = mbsp_pkg::ST_ONE;
                running_next = head.rx_byte;
            end
            mbsp_pkg::CL_TWO:
            begin
                state_next   = mbsp_pkg::ST_FIRST;
                running_next = head.rx_byte;
            end
            mbsp_pkg::CL_SYSEX:
            begin
                state_next   = mbsp_pkg::ST_SYSEX;
                running_next = head.rx_byte;
                index_next   = 9'h000;
            end
            mbsp_pkg::CL_UNDEF:
            begin
                state_next      = mbsp_pkg::ST_IDLE;
                res.result_code = mbsp_pkg::RC_UNDEF;
            end
            mbsp_pkg::CL_DATA:
            begin
                unique case (state_reg)
                    mbsp_pkg::ST_FIRST:
                    begin
                        held_next  = head.rx_byte[6:0];
                        state_next = mbsp_pkg::ST_SECOND;
                    end
                    mbsp_pkg::ST_SECOND:
                    begin
                        res.event_kind   = mbsp_pkg::EV_TWO;
                        res.status_value = running_reg;
                        res.first_data   = held_reg;
                        res.second_data  = head.rx_byte[6:0];
                        held_next        = 7'h00;
                        state_next       = mbsp_pkg::ST_FIRST;
                    end
                    mbsp_pkg::ST_ONE:
                    begin
                        res.event_kind   = mbsp_pkg::EV_ONE;
                        res.status_value = running_reg;
                        res.first_data   = head.rx_byte[6:0];
                    end
                    mbsp_pkg::ST_SYSEX:
                    begin
                        if (index_reg < eff_limit)
                        begin
                            res.event_kind   = mbsp_pkg::EV_SXDATA;
                            res.status_value = running_reg;
                            res.first_data   = head.rx_byte[6:0];
                            res.sysex_count  = index_reg;
                            index_next       = index_reg + 9'd1;
                        end
                        else
                        begin
                            index_next      = 9'h000;
                            state_next      = mbsp_pkg::ST_IDLE;
                            res.result_code = mbsp_pkg::RC_FULL;
                        end
                    end
                    default:
                    begin
                        state_next = mbsp_pkg::ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = mbsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbsp_pkg::ST_IDLE;
            running_reg   <= 8'h00;
            held_reg      <= 7'h00;
            index_reg     <= 9'h000;
            limit_reg     <= mbsp_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (pop)
            begin
                state_reg   <= state_next;
                running_reg <= running_next;
                held_reg    <= held_next;
                index_reg   <= index_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_hs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign ev.valid        = out_hs.valid;
    assign ev.event_kind   = out_reg.event_kind;
    assign ev.status_value = out_reg.status_value;
    assign ev.first_data   = out_reg.first_data;
    assign ev.second_data  = out_reg.second_data;
    assign ev.sysex_count  = out_reg.sysex_count;
    assign ev.result_code  = out_reg.result_code;

endmodule

`default_nettype wire

// File: design/mbsp_checker.sv
// Port-level checker for the MIDI byte stream parser, bound to the top level.
// Depends on mbsp_pkg.
`default_nettype none

module mbsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] event_kind,
    input wire logic [7:0] status_value,
    input wire logic [6:0] first_data,
    input wire logic [6:0] second_data,
    input wire logic [8:0] sysex_count,
    input wire logic [1:0] result_code
);

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(status_value) && $stable(sysex_count))
        else $error("result changed while stalled");

    a_error_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != mbsp_pkg::RC_OK |-> event_kind == mbsp_pkg::EV_NONE)
        else $error("error code with an event");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == mbsp_pkg::EV_NONE |-> status_value == 8'h00
            && first_data == 7'h00 && second_data == 7'h00 && sysex_count == 9'h000)
        else $error("empty result carries data");

    a_rt_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == mbsp_pkg::EV_RT |-> status_value >= mbsp_pkg::RT_MIN
            && result_code == mbsp_pkg::RC_OK)
        else $error("real-time event with a non real-time status");

    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == mbsp_pkg::EV_SXEND
            |-> status_value == mbsp_pkg::SYSEX_END_BYTE && second_data == 7'h00)
        else $error("sysex end with wrong status");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (ev.valid),
    .out_ready    (ev.ready),
    .event_kind   (ev.event_kind),
    .status_value (ev.status_value),
    .first_data   (ev.first_data),
    .second_data  (ev.second_data),
    .sysex_count  (ev.sysex_count),
    .result_code  (ev.result_code)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for midi_byte_stream_parser: directed and random MIDI byte streams.
// Uses mbsp_pkg, mbsp_byte_if and mbsp_event_if from the design; predicts every event
// with its own parser model and compares each result field by field.
`default_nettype none

module tb_top;

    localparam int unsigned SYSEX_DEPTH = 256;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_OFF    = 300;

    // MIDI status codes and channel-message nibbles.
    localparam logic [3:0] NOTE_OFF       = 4'h8;
    localparam logic [3:0] NOTE_ON        = 4'h9;
    localparam logic [3:0] POLY_PRESSURE  = 4'hA;
    localparam logic [3:0] CONTROL_CHANGE = 4'hB;
    localparam logic [3:0] PROG_CHANGE    = 4'hC;
    localparam logic [3:0] CHAN_PRESSURE  = 4'hD;
    localparam logic [3:0] PITCH_BEND     = 4'hE;
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] MTC_QUARTER    = 8'hF1;
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] SONG_SELECT    = 8'hF3;
    localparam logic [7:0] UNDEF_F4       = 8'hF4;
    localparam logic [7:0] UNDEF_F5       = 8'hF5;
    localparam logic [7:0] TUNE_REQUEST   = 8'hF6;
    localparam logic [7:0] TIMING_CLOCK   = 8'hF8;
    localparam logic [7:0] START_MSG      = 8'hFA;
    localparam logic [7:0] SYSTEM_RESET   = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [8:0] cfg_wdata;

    mbsp_byte_if  rx_if();
    mbsp_event_if ev_if();

    midi_byte_stream_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .ev        (ev_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Parser model state.
    mbsp_pkg::parse_state_t parse_st      = mbsp_pkg::ST_IDLE;
    logic [7:0]             run_status    = 8'h00;
    logic [6:0]             held_data     = 7'h00;
    logic [8:0]             sx_index      = 9'h000;
    logic [8:0]             sysex_limit_q = mbsp_pkg::LIMIT_RESET;

    mbsp_pkg::result_t expected_events[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned hold_cycles    = 0;
    bit          no_idle        = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [8:0] active_limit();
        return (sysex_limit_q > SYSEX_DEPTH) ? 9'(SYSEX_DEPTH) : sysex_limit_q;
    endfunction

    // Work out the event caused by one byte and advance the model state.
    function automatic mbsp_pkg::result_t parse_midi_byte(input logic [7:0] b);
        mbsp_pkg::result_t r;
        logic [3:0] hi;
        r = '0;
        r.event_kind = mbsp_pkg::EV_NONE;
        r.result_code = mbsp_pkg::RC_OK;
        hi = b[7:4];
        if (b[7])
        begin
            if (b >= mbsp_pkg::RT_MIN)
            begin
                r.event_kind = mbsp_pkg::EV_RT;
                r.status_value = b;
            end
            else if (parse_st == mbsp_pkg::ST_SYSEX && b == mbsp_pkg::SYSEX_END_BYTE)
            begin
                r.event_kind = mbsp_pkg::EV_SXEND;
                r.status_value = mbsp_pkg::SYSEX_END_BYTE;
                r.sysex_count = sx_index;
                parse_st = mbsp_pkg::ST_IDLE;
            end
            else
            begin
                if (hi == PROG_CHANGE || hi == CHAN_PRESSURE || b == MTC_QUARTER
                        || b == SONG_SELECT)
                    parse_st = mbsp_pkg::ST_ONE;
                else if (hi == NOTE_OFF || hi == NOTE_ON || hi == POLY_PRESSURE
                        || hi == CONTROL_CHANGE || hi == PITCH_BEND || b == SONG_POSITION)
                    parse_st = mbsp_pkg::ST_FIRST;
                else if (b == SYSEX_START)
                begin
                    sx_index = '0;
                    parse_st = mbsp_pkg::ST_SYSEX;
                end
                else
                begin
                    parse_st = mbsp_pkg::ST_IDLE;
                    r.result_code = mbsp_pkg::RC_UNDEF;
                end
                if (r.result_code == mbsp_pkg::RC_OK)
                    run_status = b;
            end
        end
        else
        begin
            case (parse_st)
                mbsp_pkg::ST_FIRST:
                begin
                    held_data = b[6:0];
                    parse_st = mbsp_pkg::ST_SECOND;
                end
                mbsp_pkg::ST_SECOND:
                begin
                    r.event_kind = mbsp_pkg::EV_TWO;
                    r.status_value = run_status;
                    r.first_data = held_data;
                    r.second_data = b[6:0];
                    held_data = '0;
                    parse_st = mbsp_pkg::ST_FIRST;
                end
                mbsp_pkg::ST_ONE:
                begin
                    r.event_kind = mbsp_pkg::EV_ONE;
                    r.status_value = run_status;
                    r.first_data = b[6:0];
                end
                mbsp_pkg::ST_SYSEX:
                begin
                    if (sx_index < active_limit())
                    begin
                        r.event_kind = mbsp_pkg::EV_SXDATA;
                        r.status_value = run_status;
                        r.first_data = b[6:0];
                        r.sysex_count = sx_index;
                        sx_index = sx_index + 9'd1;
                    end
                    else
                    begin
                        sx_index = '0;
                        parse_st = mbsp_pkg::ST_IDLE;
                        r.result_code = mbsp_pkg::RC_FULL;
                    end
                end
                default:
                    parse_st = mbsp_pkg::ST_IDLE;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    endtask

    // Offer one byte, with random idle cycles in front unless no_idle is set, until the parser takes it.
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            @(negedge clk);
            rx_if.valid <= 1'b0;
            rx_if.rx_byte <= 8'($urandom);
        end
        @(negedge clk);
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        expected_events.push_back(parse_midi_byte(b));
        bytes_sent++;
    endtask

    // Data byte, now and then preceded by a real-time byte in the middle of a message.
    task automatic send_data(input logic [6:0] d);
        if ($urandom_range(99) < 5)
            send_byte(mbsp_pkg::RT_MIN + 8'($urandom_range(7)));
        send_byte({1'b0, d});
    endtask

    task automatic wait_idle();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_sysex_limit(input logic [8:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sysex_limit_q = value;
    endtask

    task automatic send_sysex(input int unsigned len);
        send_byte(SYSEX_START);
        repeat (len) send_data(7'($urandom));
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'h40, TIMING_CLOCK, SYSTEM_RESET, {NOTE_ON, 4'h0}, 8'h00, START_MSG,
                8'h7F, {PROG_CHANGE, 4'h5}, 8'h7F, UNDEF_F4, UNDEF_F5, TUNE_REQUEST,
                mbsp_pkg::SYSEX_END_BYTE, SYSEX_START, 8'h7F, 8'h00,
                mbsp_pkg::SYSEX_END_BYTE, SYSEX_START, 8'h01, {PITCH_BEND, 4'h3},
                MTC_QUARTER, 8'h05, SONG_POSITION, 8'h01, 8'h02, SONG_SELECT, 8'h7F};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_sysex_limits();
        // Reset value of the limit: 256 bytes pass, the next one overflows.
        send_sysex(SYSEX_DEPTH + 1);
        set_sysex_limit(9'd1);
        send_sysex(2);
        send_data(7'h33);
        set_sysex_limit(9'd0);
        send_sysex(1);
        set_sysex_limit(9'd256);
        send_sysex(SYSEX_DEPTH);
        send_byte(mbsp_pkg::SYSEX_END_BYTE);
        send_sysex(SYSEX_DEPTH + 1);
    endtask

    task automatic run_random_phase(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        logic [7:0] status;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                case ($urandom_range(5))
                    0: status = {NOTE_OFF, 4'($urandom)};
                    1: status = {NOTE_ON, 4'($urandom)};
                    2: status = {POLY_PRESSURE, 4'($urandom)};
                    3: status = {CONTROL_CHANGE, 4'($urandom)};
                    4: status = {PITCH_BEND, 4'($urandom)};
                    default: status = SONG_POSITION;
                endcase
                // Leaving the status out exercises running status.
                if ($urandom_range(99) < 80)
                    send_byte(status);
                repeat ($urandom_range(1, 3))
                begin
                    send_data(7'($urandom));
                    send_data(7'($urandom));
                end
            end
            else if (pick < 55)
            begin
                case ($urandom_range(3))
                    0: status = {PROG_CHANGE, 4'($urandom)};
                    1: status = {CHAN_PRESSURE, 4'($urandom)};
                    2: status = MTC_QUARTER;
                    default: status = SONG_SELECT;
                endcase
                if ($urandom_range(99) < 80)
                    send_byte(status);
                repeat ($urandom_range(1, 3)) send_data(7'($urandom));
            end
            else if (pick < 78)
            begin
                if (active_limit() > 16 && $urandom_range(99) < 85)
                    len = $urandom_range(0, 16);
                else
                    len = $urandom_range(0, active_limit() + 1);
                send_sysex(len);
                pick = $urandom_range(99);
                if (pick < 80)
                    send_byte(mbsp_pkg::SYSEX_END_BYTE);
                else if (pick < 90)
                    send_byte(8'($urandom_range(8'h80, 8'hF6)));
            end
            else if (pick < 88)
                send_byte(mbsp_pkg::RT_MIN + 8'($urandom_range(7)));
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_random();
        set_sysex_limit(9'd1);
        run_random_phase(150);
        set_sysex_limit(9'($urandom_range(2, 8)));
        run_random_phase(150);
        set_sysex_limit(9'($urandom_range(1, 256)));
        run_random_phase(150);
        no_idle = 1'b1;
        set_sysex_limit(9'($urandom_range(3, 12)));
        run_random_phase(150);
        no_idle = 1'b0;
        set_sysex_limit(9'd256);
        run_random_phase(150);
        set_sysex_limit(9'($urandom_range(1, 32)));
        run_random_phase(150);
    endtask

    // The receiver stops for a long stretch so the queue fills and input ready drops.
    task automatic test_backpressure();
        wait_idle();
        no_idle = 1'b1;
        hold_cycles = HOLD_OFF;
        repeat (40) send_byte(8'($urandom));
        no_idle = 1'b0;
    endtask

    // Result receiver.
    initial
    begin
        ev_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                ev_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
                ev_if.ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin : check_results
        mbsp_pkg::result_t want;
        if (rst_n && ev_if.valid && ev_if.ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch("unexpected event", 9'(ev_if.event_kind), 9'h0);
            else
            begin
                want = expected_events.pop_front();
                if (ev_if.event_kind !== want.event_kind)
                    report_mismatch("event_kind", 9'(ev_if.event_kind), 9'(want.event_kind));
                if (ev_if.status_value !== want.status_value)
                    report_mismatch("status_value", 9'(ev_if.status_value),
                                    9'(want.status_value));
                if (ev_if.first_data !== want.first_data)
                    report_mismatch("first_data", 9'(ev_if.first_data), 9'(want.first_data));
                if (ev_if.second_data !== want.second_data)
                    report_mismatch("second_data", 9'(ev_if.second_data),
                                    9'(want.second_data));
                if (ev_if.sysex_count !== want.sysex_count)
                    report_mismatch("sysex_count", ev_if.sysex_count, want.sysex_count);
                if (ev_if.result_code !== want.result_code)
                    report_mismatch("result_code", 9'(ev_if.result_code),
                                    9'(want.result_code));
            end
        end
    end

    // Ends the run if no request moves on either side for too long.
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_sysex_limits();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
design/mbsp_pkg.sv
design/mbsp_byte_if.sv
design/mbsp_event_if.sv
design/mbsp_front.sv
design/mbsp_queue.sv
design/mbsp_back.sv
design/midi_byte_stream_parser.sv
design/mbsp_checker.sv
tb/sv/tb_top.sv
